// ===== rtl/swrs_pkg.sv =====
`default_nettype none
package swrs_pkg;

    localparam int W  = 32;
    localparam int F  = 16;
    localparam int CW = (W + F) / 2;

    localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

    typedef struct packed {
        logic signed [W-1:0] left_strain;
        logic signed [W-1:0] prev_right_strain;
        logic signed [W-1:0] jump_strain;
        logic signed [W-1:0] jump_velocity;
        logic [W-2:0]        modulus;
        logic [W-2:0]        density;
        logic                cell_last;
    } item_t;

    typedef struct packed {
        logic signed [W-1:0] wave1_strain;
        logic signed [W-1:0] wave1_velocity;
        logic signed [W-1:0] wave2_strain;
        logic signed [W-1:0] wave2_velocity;
        logic signed [W-1:0] speed_left;
        logic [W-2:0]        speed_right;
        logic                invalid;
        logic                result_last;
    } result_t;

    typedef struct packed {
        logic                invalid;
        logic                last;
        logic signed [W-1:0] ds;
        logic signed [W-1:0] dv;
        logic [W-2:0]        z;
        logic [CW-1:0]       c0;
    } side_t;

    // fixed-point product, magnitude truncated, saturated
    function automatic logic signed [W-1:0] fmul(input logic signed [W-1:0] a,
                                                 input logic signed [W-1:0] b);
        logic [W-1:0]   ma;
        logic [W-1:0]   mb;
        logic [2*W-1:0] p;
        logic [2*W-1:0] s;
        logic           neg;
        ma  = a[W-1] ? W'(-a) : W'(a);
        mb  = b[W-1] ? W'(-b) : W'(b);
        p   = (2*W)'(ma) * (2*W)'(mb);
        s   = p >> F;
        neg = a[W-1] ^ b[W-1];
        if (neg)
        begin
            if (|s[2*W-1:W-1])
                return MINV;
            return W'(-$signed(s[W-1:0]));
        end
        if (|s[2*W-1:W-1])
            return MAXV;
        return $signed(s[W-1:0]);
    endfunction

    function automatic logic signed [W-1:0] sat_add(input logic signed [W-1:0] a,
                                                    input logic signed [W-1:0] b);
        logic signed [W:0] s;
        s = {a[W-1], a} + {b[W-1], b};
        if (s[W] != s[W-1])
            return s[W] ? MINV : MAXV;
        return s[W-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/strain_wave_riemann_solver_top.sv =====
// Streaming elastic-wave Riemann solver, one interface per beat. A new item may be
// started in every cycle and busy stays low; each result appears on result with a
// one-cycle done strobe, in start order.
// The latency is set by two 31-step chains in series: the bit-per-stage square
// root that gives the impedance and the bit-per-stage division of the velocity
// jump by that impedance. The receiver cannot stall, so done must be taken when
// it rises. Write the coefficient only while no item is in flight.
`default_nettype none
module strain_wave_riemann_solver_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  swrs_pkg::item_t   item,
    input  logic              coeff_we,
    input  logic [31:0]       coeff_data,
    output logic              done,
    output swrs_pkg::result_t result
);
    import swrs_pkg::*;

    localparam int ZN    = W - 1;
    localparam int QN    = W - 1;
    localparam int CN    = CW;
    localparam int ZEND  = 5 + ZN;
    localparam int CDEND = 5 + QN;
    localparam int CEND  = CDEND + CN;
    localparam int VSET  = ZEND + 1;
    localparam int VEND  = VSET + QN;
    localparam int AST   = VEND + 1;
    localparam int LAT   = AST + 1;

    logic signed [W-1:0] beta_reg;
    logic                vld_reg [1:AST];
    logic                done_reg;
    result_t             res_reg;

    assign busy   = 1'b0;
    assign done   = done_reg;
    assign result = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            beta_reg <= '0;
        else if (coeff_we)
            beta_reg <= $signed(coeff_data);
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 1; k <= AST; k++)
                vld_reg[k] <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg[1] <= start && !busy;
            for (int k = 2; k <= AST; k++)
                vld_reg[k] <= vld_reg[k-1];
            done_reg <= vld_reg[AST];
        end
    end

    // front: average, m*m, products, tangent modulus
    item_t               it1_reg, it2_reg, it3_reg, it4_reg;
    logic signed [W-1:0] avg1_reg;
    logic [W-2:0]        mm1_reg;
    logic signed [W-1:0] t2_reg;
    logic signed [W-1:0] p3_reg;
    logic signed [W-1:0] dm4_reg;
    logic signed [W:0]   sum1;
    logic signed [W-1:0] mm1_next;
    logic signed [W-1:0] dm4_next;

    assign sum1     = {item.left_strain[W-1], item.left_strain}
                    + {item.prev_right_strain[W-1], item.prev_right_strain};
    assign mm1_next = fmul($signed({1'b0, item.modulus}), $signed({1'b0, item.modulus}));
    assign dm4_next = sat_add($signed({1'b0, it3_reg.modulus}), sat_add(p3_reg, p3_reg));

    always_ff @(posedge clk)
    begin
        it1_reg  <= item;
        avg1_reg <= sum1[W:1];
        mm1_reg  <= mm1_next[W-2:0];
        it2_reg  <= it1_reg;
        t2_reg   <= fmul($signed({1'b0, mm1_reg}), avg1_reg);
        it3_reg  <= it2_reg;
        p3_reg   <= fmul(beta_reg, t2_reg);
        it4_reg  <= it3_reg;
        dm4_reg  <= dm4_next;
    end

    // stage 5: dm*rho, division setup, side data
    logic [2*ZN-1:0] prod5_reg;
    logic [W-2:0]    cd_rem5_reg;
    logic [W-2:0]    cd_low5_reg;
    logic [W-2:0]    rho5_reg;
    logic            cd_sat5_reg;
    side_t           sd_reg [5:AST];
    logic [F-1:0]    cd_high4;
    logic            cd_sat4;
    logic            inv4;

    assign cd_high4 = dm4_reg[W-2:W-1-F];
    assign cd_sat4  = (W-1)'(cd_high4) >= it4_reg.density;
    assign inv4     = (dm4_reg <= 0) || (it4_reg.density == '0);

    always_ff @(posedge clk)
    begin
        prod5_reg   <= (2*ZN)'(dm4_reg[W-2:0]) * (2*ZN)'(it4_reg.density);
        cd_rem5_reg <= cd_sat4 ? '0 : (W-1)'(cd_high4);
        cd_low5_reg <= {dm4_reg[W-2-F:0], {F{1'b0}}};
        rho5_reg    <= it4_reg.density;
        cd_sat5_reg <= cd_sat4;
        sd_reg[5]   <= '{invalid: inv4, last: it4_reg.cell_last, ds: it4_reg.jump_strain,
                         dv: it4_reg.jump_velocity, z: '0, c0: '0};
    end

    // impedance square root, one root bit per stage
    logic [ZN:0]     zs_rem_reg  [0:ZN-1];
    logic [ZN-1:0]   zs_root_reg [0:ZN-1];
    logic [2*ZN-1:0] zs_x_reg    [0:ZN-1];

    // dm/rho division, one quotient bit per stage
    logic [W-2:0] cd_rem_reg [0:QN-1];
    logic [W-2:0] cd_low_reg [0:QN-1];
    logic [W-2:0] cd_d_reg   [0:QN-1];
    logic [QN-1:0] cd_q_reg  [0:QN-1];
    logic          cd_sat_reg [0:QN-1];

    // wave speed square root
    logic [CN:0]     cs_rem_reg  [0:CN-1];
    logic [CN-1:0]   cs_root_reg [0:CN-1];
    logic [2*CN-1:0] cs_x_reg    [0:CN-1];

    // dv/Z division
    logic [W-2:0]  vd_rem_reg  [0:QN-1];
    logic [W-2:0]  vd_low_reg  [0:QN-1];
    logic [W-2:0]  vd_d_reg    [0:QN-1];
    logic [QN-1:0] vd_q_reg    [0:QN-1];
    logic          vd_sat_reg  [0:QN-1];
    logic          vd_zero_reg [0:QN-1];
    logic          vd_neg_reg  [0:QN-1];

    genvar j;
    generate
        for (j = 0; j < ZN; j++)
        begin : g_zs
            logic [ZN:0]     rem_in;
            logic [ZN-1:0]   root_in;
            logic [2*ZN-1:0] x_in;
            logic [ZN+2:0]   rem4;
            logic [ZN+2:0]   trial;
            logic            ge;
            if (j == 0)
            begin : g_first
                assign rem_in  = '0;
                assign root_in = '0;
                assign x_in    = prod5_reg;
            end
            else
            begin : g_next
                assign rem_in  = zs_rem_reg[j-1];
                assign root_in = zs_root_reg[j-1];
                assign x_in    = zs_x_reg[j-1];
            end
            assign rem4  = {rem_in, x_in[2*ZN-1:2*ZN-2]};
            assign trial = (ZN+3)'({root_in, 2'b01});
            assign ge    = rem4 >= trial;
            always_ff @(posedge clk)
            begin
                zs_rem_reg[j]  <= ge ? (ZN+1)'(rem4 - trial) : rem4[ZN:0];
                zs_root_reg[j] <= {root_in[ZN-2:0], ge};
                zs_x_reg[j]    <= x_in << 2;
            end
        end

        for (j = 0; j < QN; j++)
        begin : g_cd
            logic [W-2:0]  rem_in, low_in, d_in;
            logic [QN-1:0] q_in;
            logic          sat_in;
            logic [W-1:0]  rem2;
            logic          ge;
            if (j == 0)
            begin : g_first
                assign rem_in = cd_rem5_reg;
                assign low_in = cd_low5_reg;
                assign d_in   = rho5_reg;
                assign q_in   = '0;
                assign sat_in = cd_sat5_reg;
            end
            else
            begin : g_next
                assign rem_in = cd_rem_reg[j-1];
                assign low_in = cd_low_reg[j-1];
                assign d_in   = cd_d_reg[j-1];
                assign q_in   = cd_q_reg[j-1];
                assign sat_in = cd_sat_reg[j-1];
            end
            assign rem2 = {rem_in, low_in[W-2]};
            assign ge   = rem2 >= {1'b0, d_in};
            always_ff @(posedge clk)
            begin
                cd_rem_reg[j] <= ge ? (W-1)'(rem2 - {1'b0, d_in}) : rem2[W-2:0];
                cd_low_reg[j] <= low_in << 1;
                cd_d_reg[j]   <= d_in;
                cd_q_reg[j]   <= {q_in[QN-2:0], ge};
                cd_sat_reg[j] <= sat_in;
            end
        end

        for (j = 0; j < CN; j++)
        begin : g_cs
            logic [CN:0]     rem_in;
            logic [CN-1:0]   root_in;
            logic [2*CN-1:0] x_in;
            logic [CN+2:0]   rem4;
            logic [CN+2:0]   trial;
            logic            ge;
            if (j == 0)
            begin : g_first
                logic [QN-1:0] q;
                assign q       = cd_sat_reg[QN-1] ? {QN{1'b1}} : cd_q_reg[QN-1];
                assign rem_in  = '0;
                assign root_in = '0;
                assign x_in    = (2*CN)'({q, {F{1'b0}}});
            end
            else
            begin : g_next
                assign rem_in  = cs_rem_reg[j-1];
                assign root_in = cs_root_reg[j-1];
                assign x_in    = cs_x_reg[j-1];
            end
            assign rem4  = {rem_in, x_in[2*CN-1:2*CN-2]};
            assign trial = (CN+3)'({root_in, 2'b01});
            assign ge    = rem4 >= trial;
            always_ff @(posedge clk)
            begin
                cs_rem_reg[j]  <= ge ? (CN+1)'(rem4 - trial) : rem4[CN:0];
                cs_root_reg[j] <= {root_in[CN-2:0], ge};
                cs_x_reg[j]    <= x_in << 2;
            end
        end

        // side data travels with each beat; z and c0 drop in when ready
        for (j = 6; j <= AST; j++)
        begin : g_sd
            side_t nxt;
            always_comb
            begin
                nxt = sd_reg[j-1];
                if (j == VSET)
                    nxt.z = zs_root_reg[ZN-1];
                if (j == CEND + 1)
                    nxt.c0 = cs_root_reg[CN-1];
            end
            always_ff @(posedge clk)
            begin
                sd_reg[j] <= nxt;
            end
        end
    endgenerate

    // dv/Z setup
    logic [W-1:0] dmag;
    logic [F:0]   vd_high;
    logic         vd_sat_next;
    logic [W-2:0] vs_rem_reg, vs_low_reg;
    logic         vs_sat_reg, vs_zero_reg, vs_neg_reg;

    assign dmag        = sd_reg[ZEND].dv[W-1] ? W'(-sd_reg[ZEND].dv) : W'(sd_reg[ZEND].dv);
    assign vd_high     = dmag[W-1:W-1-F];
    assign vd_sat_next = (W-1)'(vd_high) >= zs_root_reg[ZN-1];

    always_ff @(posedge clk)
    begin
        vs_rem_reg  <= vd_sat_next ? '0 : (W-1)'(vd_high);
        vs_low_reg  <= {dmag[W-2-F:0], {F{1'b0}}};
        vs_sat_reg  <= vd_sat_next;
        vs_zero_reg <= sd_reg[ZEND].dv == '0;
        vs_neg_reg  <= sd_reg[ZEND].dv[W-1];
    end

    generate
        for (j = 0; j < QN; j++)
        begin : g_vd
            logic [W-2:0]  rem_in, low_in, d_in;
            logic [QN-1:0] q_in;
            logic          sat_in, zero_in, neg_in;
            logic [W-1:0]  rem2;
            logic          ge;
            if (j == 0)
            begin : g_first
                assign rem_in  = vs_rem_reg;
                assign low_in  = vs_low_reg;
                assign d_in    = sd_reg[VSET].z;
                assign q_in    = '0;
                assign sat_in  = vs_sat_reg;
                assign zero_in = vs_zero_reg;
                assign neg_in  = vs_neg_reg;
            end
            else
            begin : g_next
                assign rem_in  = vd_rem_reg[j-1];
                assign low_in  = vd_low_reg[j-1];
                assign d_in    = vd_d_reg[j-1];
                assign q_in    = vd_q_reg[j-1];
                assign sat_in  = vd_sat_reg[j-1];
                assign zero_in = vd_zero_reg[j-1];
                assign neg_in  = vd_neg_reg[j-1];
            end
            assign rem2 = {rem_in, low_in[W-2]};
            assign ge   = rem2 >= {1'b0, d_in};
            always_ff @(posedge clk)
            begin
                vd_rem_reg[j]  <= ge ? (W-1)'(rem2 - {1'b0, d_in}) : rem2[W-2:0];
                vd_low_reg[j]  <= low_in << 1;
                vd_d_reg[j]    <= d_in;
                vd_q_reg[j]    <= {q_in[QN-2:0], ge};
                vd_sat_reg[j]  <= sat_in;
                vd_zero_reg[j] <= zero_in;
                vd_neg_reg[j]  <= neg_in;
            end
        end
    endgenerate

    // wave split
    logic [W-2:0]        qmag;
    logic signed [W-1:0] qv;
    logic signed [W:0]   a1_sum, a2_dif;
    logic signed [W-1:0] a1_reg, a2_reg;

    assign qmag   = vd_zero_reg[QN-1] ? '0
                  : (vd_sat_reg[QN-1] ? {(W-1){1'b1}} : vd_q_reg[QN-1]);
    assign qv     = vd_neg_reg[QN-1] ? W'(-$signed({1'b0, qmag})) : $signed({1'b0, qmag});
    assign a1_sum = {sd_reg[VEND].ds[W-1], sd_reg[VEND].ds} + {qv[W-1], qv};
    assign a2_dif = {sd_reg[VEND].ds[W-1], sd_reg[VEND].ds} - {qv[W-1], qv};

    always_ff @(posedge clk)
    begin
        a1_reg <= a1_sum[W:1];
        a2_reg <= a2_dif[W:1];
    end

    // output stage
    logic signed [W-1:0] p1, p2, negp;
    result_t             res_next;

    assign p1   = fmul(a1_reg, $signed({1'b0, sd_reg[AST].z}));
    assign p2   = fmul(a2_reg, $signed({1'b0, sd_reg[AST].z}));
    assign negp = (p2 == MINV) ? MAXV : W'(-p2);

    always_comb
    begin
        res_next = '0;
        res_next.result_last = sd_reg[AST].last;
        if (sd_reg[AST].invalid)
        begin
            res_next.invalid = 1'b1;
        end
        else
        begin
            res_next.wave1_strain   = a1_reg;
            res_next.wave1_velocity = p1;
            res_next.wave2_strain   = a2_reg;
            res_next.wave2_velocity = negp;
            res_next.speed_left     = W'(-$signed({1'b0, sd_reg[AST].c0}));
            res_next.speed_right    = (W-1)'(sd_reg[AST].c0);
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result strobe without a matching start beat");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.invalid |-> result.speed_right == '0 && result.wave1_strain == '0
                                   && result.wave2_velocity == '0)
        else $error("invalid result carries nonzero waves");

    a_speed_pair: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.invalid |-> result.speed_left == W'(-$signed({1'b0, result.speed_right})))
        else $error("wave speeds disagree");

    a_vd_rem: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[VEND] && !vd_sat_reg[QN-1] |-> vd_rem_reg[QN-1] < vd_d_reg[QN-1])
        else $error("dv/Z remainder out of range");

    a_cd_rem: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[CDEND] && !cd_sat_reg[QN-1] |-> cd_rem_reg[QN-1] < cd_d_reg[QN-1])
        else $error("dm/rho remainder out of range");

endmodule
`default_nettype wire

// ===== tb/sv/strain_wave_checker.sv =====
`timescale 1ns / 100ps
`default_nettype none
module strain_wave_checker (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic                   busy,
    input  swrs_pkg::item_t        item,
    input  logic                   coeff_we,
    input  logic [31:0]            coeff_data,
    input  logic                   done,
    input  swrs_pkg::result_t      result,
    output int                     fail_count,
    output int                     pending
);
    import swrs_pkg::*;

    localparam longint MAXL = 64'sd2147483647;
    localparam longint MINL = -64'sd2147483648;

    logic signed [31:0] beta;
    result_t            waves_due[$];

    assign pending = waves_due.size();

    function automatic longint clamp(input logic signed [127:0] v);
        if (v > 128'sd2147483647)
            return MAXL;
        if (v < -128'sd2147483648)
            return MINL;
        return longint'(v);
    endfunction

    // Q16.16 product: magnitude truncated, then saturated
    function automatic longint qmul(input longint a, input longint b);
        logic [127:0] ma;
        logic [127:0] mb;
        logic [127:0] p;
        ma = a < 0 ? 128'(-a) : 128'(a);
        mb = b < 0 ? 128'(-b) : 128'(b);
        p  = (ma * mb) >> 16;
        if ((a < 0) != (b < 0))
            return clamp(-$signed(p));
        return clamp($signed(p));
    endfunction

    function automatic logic [127:0] root(input logic [127:0] x);
        logic [127:0] r;
        logic [127:0] c;
        r = 0;
        for (int b = 63; b >= 0; b--)
        begin
            c = r | (128'd1 << b);
            if (c * c <= x)
                r = c;
        end
        return r;
    endfunction

    function automatic longint umax(input logic [127:0] v);
        return v > 128'd2147483647 ? MAXL : longint'(v);
    endfunction

    function automatic longint half_floor(input longint v);
        return v >>> 1;
    endfunction

    function automatic result_t solve_interface(input item_t it);
        result_t r;
        longint avg, p3, dm, rho, z, c0, qv, a1, a2, negp, ds, dv, m;
        logic [127:0] q;
        r = '0;
        r.result_last = it.cell_last;
        ds  = it.jump_strain;
        dv  = it.jump_velocity;
        m   = longint'(it.modulus);
        rho = longint'(it.density);
        avg = half_floor(longint'(it.left_strain) + longint'(it.prev_right_strain));
        p3  = qmul(beta, qmul(qmul(m, m), avg));
        dm  = clamp(m + clamp(p3 + p3));
        if (dm <= 0 || rho == 0)
        begin
            r.invalid = 1'b1;
            return r;
        end
        z  = umax(root(128'(dm) * 128'(rho)));
        q  = 128'(umax((128'(dm) << 16) / 128'(rho)));
        c0 = umax(root(q << 16));
        if (z == 0)
            qv = dv > 0 ? MAXL : (dv < 0 ? -MAXL : 0);
        else
        begin
            qv = umax((128'(dv < 0 ? -dv : dv) << 16) / 128'(z));
            if (dv < 0)
                qv = -qv;
        end
        a1   = half_floor(ds + qv);
        a2   = half_floor(ds - qv);
        negp = qmul(a2, z);
        negp = negp == MINL ? MAXL : -negp;
        r.wave1_strain   = a1[31:0];
        r.wave1_velocity = 32'(qmul(a1, z));
        r.wave2_strain   = a2[31:0];
        r.wave2_velocity = negp[31:0];
        r.speed_left     = 32'(-c0);
        r.speed_right    = c0[30:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t e;
        if (!rst_n)
        begin
            beta       <= '0;
            fail_count = 0;
            waves_due.delete();
        end
        else
        begin
            if (done)
            begin
                if (waves_due.size() == 0)
                    report_mismatch("unexpected beat", 0, 0);
                else
                begin
                    e = waves_due.pop_front();
                    if (result.wave1_strain !== e.wave1_strain)
                        report_mismatch("wave1_strain", result.wave1_strain, e.wave1_strain);
                    if (result.wave1_velocity !== e.wave1_velocity)
                        report_mismatch("wave1_velocity", result.wave1_velocity,
                                        e.wave1_velocity);
                    if (result.wave2_strain !== e.wave2_strain)
                        report_mismatch("wave2_strain", result.wave2_strain, e.wave2_strain);
                    if (result.wave2_velocity !== e.wave2_velocity)
                        report_mismatch("wave2_velocity", result.wave2_velocity,
                                        e.wave2_velocity);
                    if (result.speed_left !== e.speed_left)
                        report_mismatch("speed_left", result.speed_left, e.speed_left);
                    if (result.speed_right !== e.speed_right)
                        report_mismatch("speed_right", result.speed_right, e.speed_right);
                    if (result.invalid !== e.invalid)
                        report_mismatch("invalid", result.invalid, e.invalid);
                    if (result.result_last !== e.result_last)
                        report_mismatch("result_last", result.result_last, e.result_last);
                end
            end
            if (start && !busy)
                waves_due.push_back(solve_interface(item));
            if (coeff_we)
                beta <= coeff_data;
        end
    end
endmodule
`default_nettype wire

// ===== tb/sv/strain_wave_riemann_solver_top_tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
module strain_wave_riemann_solver_top_tb;
    import swrs_pkg::*;

    localparam int LATENCY   = 70;
    localparam int MAX_CYCLE = 400000;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    item_t   item;
    logic    coeff_we;
    logic [31:0] coeff_data;
    logic    done;
    result_t result;
    int      fail_count;
    int      pending;
    int      cycle = 0;
    int      gap_pct;

    strain_wave_riemann_solver_top u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .item       (item),
        .coeff_we   (coeff_we),
        .coeff_data (coeff_data),
        .done       (done),
        .result     (result)
    );

    strain_wave_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .item       (item),
        .coeff_we   (coeff_we),
        .coeff_data (coeff_data),
        .done       (done),
        .result     (result),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle <= cycle + 1;
        if (cycle > MAX_CYCLE)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0;
            3: return 32'(int'($urandom_range(0, 8'hff)) - 128) << 16;
            4: return 32'($urandom_range(0, 32'h1ffff)) - 32'h10000;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [30:0] pick_medium();
        case ($urandom_range(0, 7))
            0: return 31'h0;
            1: return 31'h7fff_ffff;
            2: return 31'($urandom_range(1, 3));
            3: return 31'($urandom_range(1, 32'hffff));
            default: return 31'($urandom_range(32'h4000, 32'h7f_ffff));
        endcase
    endfunction

    task automatic send_item(input item_t it);
        while ($urandom_range(0, 99) < gap_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        item  <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic hold_idle();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    task automatic write_coeff(input logic [31:0] v);
        hold_idle();
        coeff_we   <= 1'b1;
        coeff_data <= v;
        @(posedge clk);
        coeff_we   <= 1'b0;
    endtask

    task automatic send_random(input int n);
        item_t it;
        for (int i = 0; i < n; i++)
        begin
            it.left_strain       = pick_word();
            it.prev_right_strain = pick_word();
            it.jump_strain       = pick_word();
            it.jump_velocity     = pick_word();
            it.modulus           = pick_medium();
            it.density           = pick_medium();
            it.cell_last         = $urandom_range(0, 1);
            send_item(it);
        end
    endtask

    initial
    begin
        item_t it;
        logic [31:0] betas[6];
        rst_n      = 1'b0;
        start      = 1'b0;
        item       = '0;
        coeff_we   = 1'b0;
        coeff_data = '0;
        gap_pct    = 0;
        betas = '{32'h0, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_0100, 32'hffff_ff00,
                  32'h0001_0000};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, bad medium, tiny impedance, linear problem
        for (int i = 0; i < 20; i++)
        begin
            it = '0;
            it.modulus   = 31'h10000;
            it.density   = 31'h10000;
            it.cell_last = i[0];
            case (i)
                0: it.density = 0;
                1: it.modulus = 0;
                2: begin it.modulus = 1; it.density = 1; it.jump_velocity = 32'h10000; end
                3: begin it.modulus = 1; it.density = 1; it.jump_velocity = 32'hffff0000; end
                4: begin it.modulus = 1; it.density = 1; end
                5: begin it.jump_strain = 32'h8000_0000; it.jump_velocity = 32'h7fff_ffff; end
                6: begin it.jump_strain = 32'h7fff_ffff; it.jump_velocity = 32'h8000_0000; end
                7: begin it.modulus = 31'h7fff_ffff; it.density = 31'h7fff_ffff; end
                8: begin it.modulus = 31'h7fff_ffff; it.density = 1;
                         it.jump_strain = 32'h8000_0000; end
                9: begin it.left_strain = 32'h8000_0000; it.prev_right_strain = 32'h8000_0000; end
                10: begin it.left_strain = 32'h7fff_ffff; it.prev_right_strain = 32'h7fff_ffff; end
                11: begin it.modulus = 1; it.density = 31'h7fff_ffff;
                          it.jump_strain = 32'h8000_0000; it.jump_velocity = 32'h7fff_ffff; end
                default: begin it.jump_strain = $urandom(); it.jump_velocity = $urandom(); end
            endcase
            send_item(it);
        end

        for (int k = 0; k < 6; k++)
        begin
            write_coeff(betas[k]);
            gap_pct = 17;
            send_random(110);
            gap_pct = 45;
            send_random(110);
            // drain fully once per setting before the back-to-back run
            hold_idle();
            gap_pct = 0;
            send_random(105);
        end

        hold_idle();
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
`default_nettype wire

// ===== files.f =====
rtl/swrs_pkg.sv
rtl/strain_wave_riemann_solver_top.sv
tb/sv/strain_wave_checker.sv
tb/sv/strain_wave_riemann_solver_top_tb.sv
